// File: sv/gha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_pkg: shared types and constants of the heatmap accumulator
// Word structs, control states and the exponential table.
// ----------------------------------------------------------------------------
package gha_pkg;

    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] fix_x;
        logic signed [15:0] fix_y;
        logic [15:0]        fix_duration;
        logic [5:0]         pixel_col;
        logic [5:0]         pixel_row;
    } in_word_t;

    typedef struct packed {
        logic [31:0] heat_value;
        logic        no_fixations;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SIG_DIV,
        ST_SIG_CHK,
        ST_PIX_DIST,
        ST_PIX_SQ,
        ST_PIX_CHK,
        ST_IDX_DIV,
        ST_EXP,
        ST_CON_LOAD,
        ST_CON_DIV,
        ST_PIX_WR,
        ST_PIX_NEXT,
        ST_RD_LOAD,
        ST_RD_DIV,
        ST_RD_OUT
    } state_t;

    localparam int          EXP_ENTRIES = 1024;
    localparam logic [63:0] EXP_STEP    = 64'd2114190000;
    localparam logic [17:0] SQRT2PI     = 18'd164274;
    localparam logic [15:0] SF_RESET    = 16'd256;
    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

    typedef logic [31:0] exp_table_t [EXP_ENTRIES];

    function automatic exp_table_t build_exp_table();
        exp_table_t  t;
        logic [63:0] e;
        e    = 64'd1 << 31;
        t[0] = e[31:0];
        for (int i = 1; i < EXP_ENTRIES; i++) begin
            e    = (e * EXP_STEP + (64'd1 << 30)) >> 31;
            t[i] = e[31:0];
        end
        return t;
    endfunction

    localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage

// File: sv/gaussian_heatmap_accumulator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_heatmap_accumulator_unit: Gaussian fixation heatmap store
// Adds a Gaussian bump per fixation word into a map of Q8.24 sums held in
// one synchronous memory, reads back averaged pixels and clears the map.
// ----------------------------------------------------------------------------
// One word is worked on at a time. After reset a clearing pass over all
// MAP_WIDTH*MAP_HEIGHT entries runs before the first word is taken. An add
// forms sigma in a bit-serial divider, then walks the map one pixel at a
// time: a pixel outside the kernel's reach skips the division, and for one
// inside the same divider runs twice (10 bits for the table index, 31 bits
// for the contribution) around a memory read-modify-write. A read does one
// memory read and a 32-bit division by the fixation count; a clear writes
// all MAP_WIDTH*MAP_HEIGHT entries, one memory entry per cycle.
module gaussian_heatmap_accumulator_unit #(
    parameter int MAP_WIDTH  = 64,
    parameter int MAP_HEIGHT = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  gha_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output gha_pkg::out_word_t m_data
);

    localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (MAP_WIDTH > 1) ? $clog2(MAP_WIDTH) : 1;
    localparam int RW    = (MAP_HEIGHT > 1) ? $clog2(MAP_HEIGHT) : 1;

    gha_pkg::state_t    state_reg, state_next;
    logic [15:0]        sf_reg, sf_next;
    logic [15:0]        count_reg, count_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic [CW-1:0]      col_reg, col_next;
    logic [RW-1:0]      row_reg, row_next;
    logic signed [15:0] fx_reg, fx_next;
    logic signed [15:0] fy_reg, fy_next;
    logic [63:0]        s2_reg, s2_next;
    logic [49:0]        den_reg, den_next;
    logic signed [17:0] dx_reg, dx_next;
    logic signed [17:0] dy_reg, dy_next;
    logic [31:0]        dx2_reg, dx2_next;
    logic [31:0]        dy2_reg, dy2_next;
    logic               oob_reg, oob_next;
    logic [5:0]         div_cnt_reg, div_cnt_next;
    logic [63:0]        div_rem_reg, div_rem_next;
    logic [31:0]        div_nq_reg, div_nq_next;
    logic [63:0]        div_den_reg, div_den_next;
    logic               m_valid_reg, m_valid_next;
    gha_pkg::out_word_t m_data_reg, m_data_next;
    logic [31:0]        exp_q_reg;
    logic [31:0]        mem_q_reg;

    logic [31:0]        heat_mem [DEPTH];
    logic               mem_re;
    logic               mem_we;
    logic [31:0]        mem_wdata;

    logic [64:0]        div_t;
    logic               div_ge;
    logic [64:0]        div_diff;
    logic [63:0]        div_rem_step;
    logic [31:0]        div_nq_step;
    logic signed [35:0] dx_sq;
    logic signed [35:0] dy_sq;
    logic [32:0]        d2;
    logic [32:0]        sum;
    logic [31:0]        sig;

    assign s_ready = (state_reg == gha_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign div_t        = {div_rem_reg, div_nq_reg[31]};
    assign div_ge       = div_t >= {1'b0, div_den_reg};
    assign div_diff     = div_t - {1'b0, div_den_reg};
    assign div_rem_step = div_ge ? div_diff[63:0] : div_t[63:0];
    assign div_nq_step  = {div_nq_reg[30:0], div_ge};

    assign dx_sq = dx_reg * dx_reg;
    assign dy_sq = dy_reg * dy_reg;
    assign d2    = {1'b0, dx2_reg} + {1'b0, dy2_reg};
    assign sum   = {1'b0, mem_q_reg} + {2'b0, div_nq_reg[30:0]};
    assign sig   = div_nq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gha_pkg::ST_CLEAR;
            sf_reg      <= gha_pkg::SF_RESET;
            count_reg   <= '0;
            addr_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sf_reg      <= sf_next;
            count_reg   <= count_next;
            addr_reg    <= addr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        col_reg     <= col_next;
        row_reg     <= row_next;
        fx_reg      <= fx_next;
        fy_reg      <= fy_next;
        s2_reg      <= s2_next;
        den_reg     <= den_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        dx2_reg     <= dx2_next;
        dy2_reg     <= dy2_next;
        oob_reg     <= oob_next;
        div_cnt_reg <= div_cnt_next;
        div_rem_reg <= div_rem_next;
        div_nq_reg  <= div_nq_next;
        div_den_reg <= div_den_next;
        m_data_reg  <= m_data_next;
        exp_q_reg   <= gha_pkg::EXP_TABLE[div_nq_reg[9:0]];
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            heat_mem[addr_reg] <= mem_wdata;
        end
        if (mem_re) begin
            mem_q_reg <= heat_mem[addr_reg];
        end
    end

    always_comb begin
        state_next   = state_reg;
        sf_next      = cfg_we ? cfg_wdata : sf_reg;
        count_next   = count_reg;
        addr_next    = addr_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        fx_next      = fx_reg;
        fy_next      = fy_reg;
        s2_next      = s2_reg;
        den_next     = den_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        dx2_next     = dx2_reg;
        dy2_next     = dy2_reg;
        oob_next     = oob_reg;
        div_cnt_next = div_cnt_reg;
        div_rem_next = div_rem_reg;
        div_nq_next  = div_nq_reg;
        div_den_next = div_den_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        mem_re       = 1'b0;
        mem_we       = 1'b0;
        mem_wdata    = '0;

        unique case (state_reg)
            gha_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == AW'(DEPTH - 1)) begin
                    count_next = '0;
                    state_next = gha_pkg::ST_IDLE;
                end
            end
            gha_pkg::ST_IDLE: begin
                if (s_valid) begin
                    case (s_data.mode)
                        gha_pkg::MODE_ADD: begin
                            if (s_data.fix_duration != '0) begin
                                fx_next      = s_data.fix_x;
                                fy_next      = s_data.fix_y;
                                div_rem_next = '0;
                                div_nq_next  = {s_data.fix_duration, 16'b0};
                                div_den_next = (sf_reg == '0) ? 64'd1 : 64'(sf_reg);
                                div_cnt_next = 6'd32;
                                state_next   = gha_pkg::ST_SIG_DIV;
                            end
                        end
                        gha_pkg::MODE_READ: begin
                            oob_next   = (11'(s_data.pixel_col) >= 11'(MAP_WIDTH)) ||
                                         (11'(s_data.pixel_row) >= 11'(MAP_HEIGHT));
                            addr_next  = AW'(32'(s_data.pixel_row) * MAP_WIDTH +
                                             32'(s_data.pixel_col));
                            mem_re     = 1'b0;
                            state_next = gha_pkg::ST_RD_LOAD;
                        end
                        gha_pkg::MODE_CLEAR: begin
                            addr_next  = '0;
                            state_next = gha_pkg::ST_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            gha_pkg::ST_SIG_DIV: begin
                div_rem_next = div_rem_step;
                div_nq_next  = div_nq_step;
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == 6'd1) begin
                    state_next = gha_pkg::ST_SIG_CHK;
                end
            end
            gha_pkg::ST_SIG_CHK: begin
                if (sig == '0) begin
                    state_next = gha_pkg::ST_IDLE;
                end else begin
                    s2_next    = 64'(sig) * 64'(sig);
                    den_next   = 50'(sig) * 50'(gha_pkg::SQRT2PI);
                    addr_next  = '0;
                    col_next   = '0;
                    row_next   = '0;
                    state_next = gha_pkg::ST_PIX_DIST;
                end
            end
            gha_pkg::ST_PIX_DIST: begin
                dx_next    = $signed(18'(col_reg) << 4) - {{2{fx_reg[15]}}, fx_reg};
                dy_next    = $signed(18'(row_reg) << 4) - {{2{fy_reg[15]}}, fy_reg};
                state_next = gha_pkg::ST_PIX_SQ;
            end
            gha_pkg::ST_PIX_SQ: begin
                dx2_next   = dx_sq[31:0];
                dy2_next   = dy_sq[31:0];
                state_next = gha_pkg::ST_PIX_CHK;
            end
            gha_pkg::ST_PIX_CHK: begin
                mem_re = 1'b1;
                if (64'({d2, 3'b0}) >= s2_reg) begin
                    state_next = gha_pkg::ST_PIX_NEXT;
                end else begin
                    div_rem_next = 64'({d2, 3'b0});
                    div_nq_next  = '0;
                    div_den_next = s2_reg;
                    div_cnt_next = 6'd10;
                    state_next   = gha_pkg::ST_IDX_DIV;
                end
            end
            gha_pkg::ST_IDX_DIV: begin
                div_rem_next = div_rem_step;
                div_nq_next  = div_nq_step;
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == 6'd1) begin
                    state_next = gha_pkg::ST_EXP;
                end
            end
            gha_pkg::ST_EXP: begin
                state_next = gha_pkg::ST_CON_LOAD;
            end
            gha_pkg::ST_CON_LOAD: begin
                div_rem_next = 64'(exp_q_reg[31:14]);
                div_nq_next  = {exp_q_reg[13:0], 18'b0};
                div_den_next = 64'(den_reg);
                div_cnt_next = 6'd31;
                state_next   = gha_pkg::ST_CON_DIV;
            end
            gha_pkg::ST_CON_DIV: begin
                div_rem_next = div_rem_step;
                div_nq_next  = div_nq_step;
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == 6'd1) begin
                    state_next = gha_pkg::ST_PIX_WR;
                end
            end
            gha_pkg::ST_PIX_WR: begin
                mem_we     = 1'b1;
                mem_wdata  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                state_next = gha_pkg::ST_PIX_NEXT;
            end
            gha_pkg::ST_PIX_NEXT: begin
                addr_next = addr_reg + 1'b1;
                if (col_reg == CW'(MAP_WIDTH - 1)) begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                end else begin
                    col_next = col_reg + 1'b1;
                end
                if (addr_reg == AW'(DEPTH - 1)) begin
                    if (count_reg != gha_pkg::COUNT_MAX) begin
                        count_next = count_reg + 1'b1;
                    end
                    state_next = gha_pkg::ST_IDLE;
                end else begin
                    state_next = gha_pkg::ST_PIX_DIST;
                end
            end
            gha_pkg::ST_RD_LOAD: begin
                mem_re       = 1'b1;
                div_cnt_next = 6'd32;
                div_den_next = 64'(count_reg);
                div_rem_next = '0;
                state_next   = gha_pkg::ST_RD_DIV;
            end
            gha_pkg::ST_RD_DIV: begin
                if (div_cnt_reg == 6'd32) begin
                    div_nq_next  = mem_q_reg;
                    div_cnt_next = 6'd33 - 6'd1;
                    if (count_reg == '0 || oob_reg) begin
                        state_next = gha_pkg::ST_RD_OUT;
                    end else begin
                        div_cnt_next = 6'd31;
                        div_rem_next = div_rem_reg;
                    end
                end else begin
                    div_rem_next = div_rem_step;
                    div_nq_next  = div_nq_step;
                    div_cnt_next = div_cnt_reg - 1'b1;
                    if (div_cnt_reg == 6'd0) begin
                        state_next = gha_pkg::ST_RD_OUT;
                    end
                end
            end
            gha_pkg::ST_RD_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.heat_value   = (count_reg == '0 || oob_reg) ? '0 : div_nq_reg;
                    m_data_next.no_fixations = (count_reg == '0);
                    state_next               = gha_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gha_pkg::ST_IDLE;
            end
        endcase
    end

    a_mem_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == gha_pkg::ST_CLEAR || state_reg == gha_pkg::ST_PIX_WR))
        else $error("memory written outside clear or pixel write");

    a_count_change: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(count_reg) |->
            ($past(state_reg) == gha_pkg::ST_PIX_NEXT || $past(state_reg) == gha_pkg::ST_CLEAR))
        else $error("fixation count changed outside add or clear");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == gha_pkg::ST_RD_OUT)
        else $error("result word raised outside read completion");

    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gha_pkg::ST_IDX_DIV || state_reg == gha_pkg::ST_CON_DIV ||
         state_reg == gha_pkg::ST_SIG_DIV) |-> (div_rem_reg < div_den_reg))
        else $error("divider remainder not below divisor");

endmodule
